>>> hdl/tro_pkg.sv
package tro_pkg;

  // Rational coefficients: K_A, K_B and K_C in Q30, K_D in Q24
  localparam logic [31:0] K_A = 32'd3554242634;
  localparam logic [27:0] K_B = 28'd210199872;
  localparam logic [32:0] K_C = 33'd4525402578;
  localparam logic [30:0] K_D = 31'd1198137011;

  // Divide by 45 as (n * DIV45_M) >> DIV45_S, exact for n below 2^28
  localparam int          DIV45_MW   = 27;
  localparam logic [26:0] DIV45_M    = 27'd95443718;
  localparam int          DIV45_S    = 32;
  localparam logic [5:0]  DEG45      = 6'd45;
  // Half of 45 in whole units, rounded down
  localparam logic [4:0]  DEG45_HALF = 5'd22;

  // Octant flags that ride along with each request
  typedef struct packed {
    logic recip;
    logic neg;
  } tro_flags_t;

endpackage

>>> hdl/tangent_rational_octant.sv
// Throughput: one angle per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset: rst_ni clears all valid bits asynchronously; data registers keep no reset.
// Depth is set by two bit-per-stage dividers: rational quotient and reciprocal;
//   the octant split and the angle scaling divide by 45 through reciprocal multiplies.
module tangent_rational_octant #(
  parameter int ANGLE_FRAC_BITS  = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle_degrees
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] tangent
  output logic [0:0]  m_axis_tuser    // [0] saturated
);
  import tro_pkg::*;

  localparam int EW = 6 + ANGLE_FRAC_BITS;          // width of 45 degrees
  localparam logic [EW-1:0] EIGHTH = EW'(45 << ANGLE_FRAC_BITS);
  localparam int HW  = 32 - ANGLE_FRAC_BITS;        // whole degrees of the magnitude
  localparam int PAW = HW + DIV45_MW;               // octant split product
  localparam int YW  = 36;                          // scaled angle numerator
  localparam int N4  = 32 + RESULT_FRAC_BITS;       // reciprocal numerator

  // Global advance: the whole pipe moves whenever the output slot frees up
  logic en;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 0: strip the sign (most negative input keeps magnitude 2^31)
  logic        v0_q;
  logic [31:0] mag0_q;
  logic        neg0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg0_q <= s_axis_tdata[31];
      mag0_q <= s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
    end
  end

  // Divide by 45 degrees: whole degrees / 45 by reciprocal multiply, the
  // fraction bits pass straight into the remainder. Low three quotient bits
  // give the octant mod 360.
  logic                       va_q;
  logic [HW-1:0]              hia_q;
  logic [ANGLE_FRAC_BITS-1:0] loa_q;
  logic                       nega_q;
  logic [PAW-1:0]             proda_q;

  logic [HW-1:0]              qa;
  logic [HW-1:0]              qa45;
  logic [5:0]                 rema;

  logic                       vb_q;
  logic [2:0]                 octb_q;
  logic [EW-1:0]              remb_q;
  logic                       negb_q;

  assign qa   = HW'(proda_q >> DIV45_S);
  assign qa45 = qa * HW'(DEG45);
  assign rema = 6'(hia_q - qa45);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= v0_q;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hia_q   <= mag0_q[31:ANGLE_FRAC_BITS];
      loa_q   <= mag0_q[ANGLE_FRAC_BITS-1:0];
      nega_q  <= neg0_q;
      proda_q <= PAW'(mag0_q[31:ANGLE_FRAC_BITS]) * PAW'(DIV45_M);
      octb_q  <= qa[2:0];
      remb_q  <= {rema, loa_q};
      negb_q  <= nega_q;
    end
  end

  // Stage 1: fold into 0..45 degrees, derive reciprocal and negate flags
  logic          v1_q;
  logic [EW-1:0] fold1_q;
  tro_flags_t    f1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold1_q  <= octb_q[0] ? (EIGHTH - remb_q) : remb_q;
      f1_q.recip <= octb_q[0] ^ octb_q[1];
      f1_q.neg   <= negb_q ^ octb_q[1];
    end
  end

  // Scale folded angle to x in Q30, rounded: x = (fold * 2^(30-AFB) + 22) / 45.
  // Long division in two 18-bit digits, each by reciprocal multiply.
  logic [YW-1:0] y;
  logic          vx1_q, vx2_q, vx3_q, vx4_q;
  tro_flags_t    fx1_q, fx2_q, fx3_q, fx4_q;
  logic [17:0]   yh1_q, yl1_q;
  logic [44:0]   prod1_q;
  logic [12:0]   qh;
  logic [17:0]   qh45;
  logic [5:0]    rh;
  logic [12:0]   qh2_q, qh3_q;
  logic [23:0]   nx2_q;
  logic [50:0]   prod3_q;
  logic [30:0]   x4_q;

  assign y    = (YW'(fold1_q) << (30 - ANGLE_FRAC_BITS)) + YW'(DEG45_HALF);
  assign qh   = 13'(prod1_q >> DIV45_S);
  assign qh45 = 18'(qh) * 18'(DEG45);
  assign rh   = 6'(yh1_q - qh45);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx1_q <= 1'b0;
      vx2_q <= 1'b0;
      vx3_q <= 1'b0;
      vx4_q <= 1'b0;
    end else if (en) begin
      vx1_q <= v1_q;
      vx2_q <= vx1_q;
      vx3_q <= vx2_q;
      vx4_q <= vx3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yh1_q   <= y[35:18];
      yl1_q   <= y[17:0];
      prod1_q <= 45'(y[35:18]) * 45'(DIV45_M);
      fx1_q   <= f1_q;
      qh2_q   <= qh;
      nx2_q   <= {rh, yl1_q};
      fx2_q   <= fx1_q;
      prod3_q <= 51'(nx2_q) * 51'(DIV45_M);
      qh3_q   <= qh2_q;
      fx3_q   <= fx2_q;
      x4_q    <= {qh3_q, 18'(prod3_q >> DIV45_S)};
      fx4_q   <= fx3_q;
    end
  end

  // Polynomial terms of the rational form
  logic        r_v;
  logic [63:0] r_num;
  logic [32:0] r_den;
  tro_flags_t  r_f;

  tro_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vx4_q),
    .x_i     (x4_q),
    .flags_i (fx4_q),
    .valid_o (r_v),
    .num_o   (r_num),
    .den_o   (r_den),
    .flags_o (r_f)
  );

  // t = round(x*P / Q), Q30
  logic        d3_v;
  logic [63:0] d3_quo;
  tro_flags_t  d3_f;

  tro_div #(.NW(64), .DW(33), .SW(2)) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_v),
    .num_i   (r_num),
    .den_i   (r_den),
    .side_i  (r_f),
    .valid_o (d3_v),
    .quo_o   (d3_quo),
    .side_o  (d3_f)
  );

  // Reciprocal of t; t rides along for the direct path and pole check
  logic [32:0]   t3;
  logic [N4-1:0] num4;
  logic          d4_v;
  logic [N4-1:0] d4_quo;
  logic [34:0]   d4_side;

  assign t3   = d3_quo[32:0];
  assign num4 = (N4'(1) << (30 + RESULT_FRAC_BITS)) + N4'(t3 >> 1);

  tro_div #(.NW(N4), .DW(33), .SW(35)) u_div_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d3_v),
    .num_i   (num4),
    .den_i   (t3),
    .side_i  ({t3, d3_f}),
    .valid_o (d4_v),
    .quo_o   (d4_quo),
    .side_o  (d4_side)
  );

  // Final select, sign and saturation
  logic [32:0]   t4;
  tro_flags_t    f4;
  logic [33:0]   dsum;
  logic [N4-1:0] mag;
  logic          pole;
  logic [31:0]   res_d;
  logic          sat_d;
  logic [31:0]   tdata_q;
  logic          sat_q;

  assign t4   = d4_side[34:2];
  assign f4   = d4_side[1:0];
  assign dsum = {1'b0, t4} + (34'(1) << (29 - RESULT_FRAC_BITS));
  assign pole = f4.recip && (t4 == 33'd0);
  assign mag  = f4.recip ? d4_quo : N4'(dsum >> (30 - RESULT_FRAC_BITS));

  always_comb begin
    if (f4.neg) begin
      sat_d = pole || (mag > N4'(32'h8000_0000));
      res_d = sat_d ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      sat_d = pole || (mag > N4'(32'h7FFF_FFFF));
      res_d = sat_d ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= d4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= res_d;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = tdata_q;
  assign m_axis_tuser[0] = sat_q;

  // A saturated result is always one of the two clamp values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturated flag without clamp value");

  // A finished item from the last divider lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && d4_v |=> m_axis_tvalid)
    else $error("result dropped at output register");

  // Pole always saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && d4_v && pole |=> m_axis_tuser[0])
    else $error("pole not saturated");

endmodule

>>> hdl/tro_div.sv
module tro_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  // One quotient bit per stage, restoring form
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   cand;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cand = {rem_in, nq_in[NW-1]};
    assign diff = cand - {1'b0, den_in};
    assign ge   = (cand >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : cand[DW-1:0];
        nq_q[k]   <= {nq_in[NW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

>>> hdl/tro_ratio.sv
module tro_ratio (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [30:0]        x_i,
  input  tro_pkg::tro_flags_t flags_i,
  output logic               valid_o,
  output logic [63:0]        num_o,
  output logic [32:0]        den_o,
  output tro_pkg::tro_flags_t flags_o
);
  import tro_pkg::*;

  logic       v1_q, v2_q, v3_q, v4_q;
  tro_flags_t f1_q, f2_q, f3_q, f4_q;

  // Stage 1: square
  logic [61:0] sq;
  logic [61:0] sq_r;
  logic [30:0] xa_q, x2_q;
  assign sq   = 62'(x_i) * 62'(x_i);
  assign sq_r = sq + (62'(1) << 29);

  // Stage 2: numerator and denominator polynomial terms
  logic [58:0] bx;
  logic [24:0] x2s;
  logic [30:0] dm;
  logic [55:0] tmp;
  logic [31:0] p2_q;
  logic [55:0] tmp_q;
  logic [30:0] xb_q;
  assign bx  = 59'(K_B) * 59'(x2_q);
  assign x2s = x2_q[30:6];
  assign dm  = K_D - 31'(x2s);
  assign tmp = 56'(x2s) * 56'(dm);

  // Stage 3: x*P and Q
  logic [62:0] prod_q;
  logic [32:0] q3_q;

  // Stage 4: rounded numerator
  logic [63:0] num_q;
  logic [32:0] q4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q   <= x_i;
      x2_q   <= sq_r[60:30];
      f1_q   <= flags_i;
      p2_q   <= K_A - 32'(bx >> 30);
      tmp_q  <= tmp;
      xb_q   <= xa_q;
      f2_q   <= f1_q;
      prod_q <= 63'(xb_q) * 63'(p2_q);
      q3_q   <= K_C - 33'(tmp_q >> 24);
      f3_q   <= f2_q;
      num_q  <= 64'(prod_q) + 64'(q3_q >> 1);
      q4_q   <= q3_q;
      f4_q   <= f3_q;
    end
  end

  assign valid_o = v4_q;
  assign num_o   = num_q;
  assign den_o   = q4_q;
  assign flags_o = f4_q;

endmodule
